// ===== rtl/rmst_pkg.sv =====
`timescale 1ns / 1ps
package rmst_pkg;

  localparam int CAPACITY     = 1024;
  localparam int VALUE_WIDTH  = 32;
  localparam int CMD_WIDTH    = 2;
  localparam int POS_WIDTH    = 11;
  localparam int STATUS_WIDTH = 2;

  localparam logic [CMD_WIDTH-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_POS_RANGE = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_BAD_RANGE = 2'd2;

  typedef struct packed {
    logic load_item;
    logic walk_init;
    logic sweep_start;
    logic sweep_step;
    logic leaf_write;
    logic sib_read;
    logic parent_write;
    logic lo_read;
    logic lo_take;
    logic hi_read;
    logic hi_take;
    logic level_shift;
    logic out_load;
  } rmst_ctl_t;

  typedef struct packed {
    logic [CMD_WIDTH-1:0] command;
    logic                 upd_ok;
    logic                 qry_ok;
    logic                 lo_lt_hi;
    logic                 lo_odd;
    logic                 hi_odd;
    logic                 parent_root;
    logic                 sweep_last;
  } rmst_sts_t;

endpackage

// ===== rtl/rmst_in_if.sv =====
`timescale 1ns / 1ps
interface rmst_in_if #(
  parameter int VALUE_WIDTH = rmst_pkg::VALUE_WIDTH
);
  logic                             valid;
  logic                             ready;
  logic [rmst_pkg::CMD_WIDTH-1:0]   command;
  logic [rmst_pkg::POS_WIDTH-1:0]   position;
  logic [VALUE_WIDTH-1:0]           new_value;
  logic [rmst_pkg::POS_WIDTH-1:0]   range_low;
  logic [rmst_pkg::POS_WIDTH-1:0]   range_high;

  modport source (
    output valid, command, position, new_value, range_low, range_high,
    input  ready
  );
  modport sink (
    input  valid, command, position, new_value, range_low, range_high,
    output ready
  );
endinterface

// ===== rtl/rmst_out_if.sv =====
`timescale 1ns / 1ps
interface rmst_out_if #(
  parameter int VALUE_WIDTH = rmst_pkg::VALUE_WIDTH
);
  logic                              valid;
  logic                              ready;
  logic [VALUE_WIDTH-1:0]            max_value;
  logic [rmst_pkg::STATUS_WIDTH-1:0] status;

  modport source (
    output valid, max_value, status,
    input  ready
  );
  modport sink (
    input  valid, max_value, status,
    output ready
  );
endinterface

// ===== rtl/rmst_ram.sv =====
`timescale 1ns / 1ps
module rmst_ram #(
  parameter int WIDTH = rmst_pkg::VALUE_WIDTH,
  parameter int DEPTH = 2 * rmst_pkg::CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rmst_ctrl.sv =====
`timescale 1ns / 1ps
module rmst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rmst_pkg::rmst_sts_t sts,
  output rmst_pkg::rmst_ctl_t ctl
);

  localparam logic [3:0] S_SWEEP     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DECODE    = 4'd2;
  localparam logic [3:0] S_CMD_SWEEP = 4'd3;
  localparam logic [3:0] S_UPD_LEAF  = 4'd4;
  localparam logic [3:0] S_UPD_READ  = 4'd5;
  localparam logic [3:0] S_UPD_WAIT  = 4'd6;
  localparam logic [3:0] S_Q_TEST    = 4'd7;
  localparam logic [3:0] S_Q_LO_WAIT = 4'd8;
  localparam logic [3:0] S_Q_HI_TEST = 4'd9;
  localparam logic [3:0] S_Q_HI_WAIT = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE) && !cfg_we;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.walk_init = 1'b1;
        case (sts.command)
          rmst_pkg::CMD_UPDATE: state_next = sts.upd_ok ? S_UPD_LEAF : S_DONE;
          rmst_pkg::CMD_QUERY:  state_next = sts.qry_ok ? S_Q_TEST : S_DONE;
          rmst_pkg::CMD_CLEAR: begin
            ctl.sweep_start = 1'b1;
            state_next      = S_CMD_SWEEP;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CMD_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_UPD_LEAF: begin
        ctl.leaf_write = 1'b1;
        state_next     = S_UPD_READ;
      end
      S_UPD_READ: begin
        ctl.sib_read = 1'b1;
        state_next   = S_UPD_WAIT;
      end
      S_UPD_WAIT: begin
        ctl.parent_write = 1'b1;
        state_next       = sts.parent_root ? S_DONE : S_UPD_READ;
      end
      S_Q_TEST: begin
        if (!sts.lo_lt_hi) begin
          state_next = S_DONE;
        end else if (sts.lo_odd) begin
          ctl.lo_read = 1'b1;
          state_next  = S_Q_LO_WAIT;
        end else begin
          state_next = S_Q_HI_TEST;
        end
      end
      S_Q_LO_WAIT: begin
        ctl.lo_take = 1'b1;
        state_next  = S_Q_HI_TEST;
      end
      S_Q_HI_TEST: begin
        if (sts.hi_odd) begin
          ctl.hi_read = 1'b1;
          state_next  = S_Q_HI_WAIT;
        end else begin
          ctl.level_shift = 1'b1;
          state_next      = S_Q_TEST;
        end
      end
      S_Q_HI_WAIT: begin
        ctl.hi_take     = 1'b1;
        ctl.level_shift = 1'b1;
        state_next      = S_Q_TEST;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cfg_we) begin
      ctl.sweep_start = 1'b1;
      ctl.sweep_step  = 1'b0;
      state_next      = S_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rmst_dp.sv =====
`timescale 1ns / 1ps
module rmst_dp #(
  parameter int CAPACITY    = rmst_pkg::CAPACITY,
  parameter int VALUE_WIDTH = rmst_pkg::VALUE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rmst_pkg::POS_WIDTH-1:0]    cfg_wdata,
  input  logic [rmst_pkg::CMD_WIDTH-1:0]    in_command,
  input  logic [rmst_pkg::POS_WIDTH-1:0]    in_position,
  input  logic [VALUE_WIDTH-1:0]            in_new_value,
  input  logic [rmst_pkg::POS_WIDTH-1:0]    in_range_low,
  input  logic [rmst_pkg::POS_WIDTH-1:0]    in_range_high,
  output logic [VALUE_WIDTH-1:0]            out_max_value,
  output logic [rmst_pkg::STATUS_WIDTH-1:0] out_status,
  input  rmst_pkg::rmst_ctl_t               ctl,
  output rmst_pkg::rmst_sts_t               sts
);

  localparam int PW         = rmst_pkg::POS_WIDTH;
  localparam int DEPTH      = 2 * CAPACITY;
  localparam int AW         = $clog2(DEPTH);
  localparam int IW         = AW + 1;
  localparam int POS_MAX    = (1 << PW) - 1;
  localparam int SIZE_RESET = (CAPACITY > POS_MAX) ? POS_MAX : CAPACITY;

  logic [rmst_pkg::CMD_WIDTH-1:0] command;
  logic [PW-1:0]                  position;
  logic [VALUE_WIDTH-1:0]         new_value;
  logic [PW-1:0]                  range_low;
  logic [PW-1:0]                  range_high;
  logic [PW-1:0]                  size_in_use;

  logic [IW-1:0]          idx;
  logic [IW-1:0]          lo;
  logic [IW-1:0]          hi;
  logic [VALUE_WIDTH-1:0] carry;
  logic [VALUE_WIDTH-1:0] best;
  logic [AW-1:0]          sweep_cnt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic [VALUE_WIDTH-1:0]            upd_max;
  logic [VALUE_WIDTH-1:0]            best_max;
  logic [IW-1:0]                     parent;
  logic [rmst_pkg::STATUS_WIDTH-1:0] item_status;

  assign parent   = idx >> 1;
  assign upd_max  = (carry > ram_rdata) ? carry : ram_rdata;
  assign best_max = (best > ram_rdata) ? best : ram_rdata;

  always_comb begin
    sts.command     = command;
    sts.upd_ok      = (position != '0) && (position <= size_in_use);
    sts.qry_ok      = (range_low != '0) && (range_high <= size_in_use)
                      && (range_low <= range_high);
    sts.lo_lt_hi    = lo < hi;
    sts.lo_odd      = lo[0];
    sts.hi_odd      = hi[0];
    sts.parent_root = parent == IW'(1);
    sts.sweep_last  = sweep_cnt == AW'(DEPTH - 1);
  end

  always_comb begin
    item_status = rmst_pkg::ST_OK;
    if (command == rmst_pkg::CMD_UPDATE && !sts.upd_ok) begin
      item_status = rmst_pkg::ST_POS_RANGE;
    end else if (command == rmst_pkg::CMD_QUERY && !sts.qry_ok) begin
      item_status = rmst_pkg::ST_BAD_RANGE;
    end
  end

  always_comb begin
    ram_we    = ctl.sweep_step || ctl.leaf_write || ctl.parent_write;
    ram_waddr = parent[AW-1:0];
    ram_wdata = upd_max;
    if (ctl.sweep_step) begin
      ram_waddr = sweep_cnt;
      ram_wdata = '0;
    end else if (ctl.leaf_write) begin
      ram_waddr = idx[AW-1:0];
      ram_wdata = new_value;
    end
    if (ctl.lo_read) begin
      ram_raddr = lo[AW-1:0];
    end else if (ctl.hi_read) begin
      ram_raddr = hi[AW-1:0] & ~AW'(1);
    end else if (ctl.sib_read) begin
      ram_raddr = idx[AW-1:0] ^ AW'(1);
    end else begin
      ram_raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= PW'(SIZE_RESET);
      sweep_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          size_in_use <= PW'(1);
        end else if (32'(cfg_wdata) > CAPACITY) begin
          size_in_use <= PW'(SIZE_RESET);
        end else begin
          size_in_use <= cfg_wdata;
        end
      end
      if (ctl.sweep_start) begin
        sweep_cnt <= '0;
      end else if (ctl.sweep_step) begin
        sweep_cnt <= sweep_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      command    <= in_command;
      position   <= in_position;
      new_value  <= in_new_value;
      range_low  <= in_range_low;
      range_high <= in_range_high;
      best       <= '0;
    end
    if (ctl.walk_init) begin
      idx <= IW'(CAPACITY) + IW'(position) - IW'(1);
      lo  <= IW'(CAPACITY) + IW'(range_low) - IW'(1);
      hi  <= IW'(CAPACITY) + IW'(range_high);
    end
    if (ctl.leaf_write) begin
      carry <= new_value;
    end
    if (ctl.parent_write) begin
      carry <= upd_max;
      idx   <= parent;
    end
    if (ctl.lo_take || ctl.hi_take) begin
      best <= best_max;
    end
    if (ctl.lo_take) begin
      lo <= lo + IW'(1);
    end
    if (ctl.level_shift) begin
      lo <= lo >> 1;
      hi <= hi >> 1;
    end
    if (ctl.out_load) begin
      out_max_value <= best;
      out_status    <= item_status;
    end
  end

  rmst_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_tree_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/range_max_segment_tree.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Contents
// request   in         command, position, new_value, range_low, range_high
// response  out        max_value, status
// config    in         cfg_we, cfg_wdata (size_in_use)
//
// An update walks from the leaf to the root through one tree RAM read port, with one
// sibling read and one parent write per level.
// A query walks the levels upward, limited by the same read port.
// A clear command, reset and every size write run a sweep over all 2*CAPACITY tree RAM
// words that zeroes them; no request word is taken during it.
// A finished response waits in its output register without blocking the next request.
module range_max_segment_tree #(
  parameter int CAPACITY    = rmst_pkg::CAPACITY,
  parameter int VALUE_WIDTH = rmst_pkg::VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rmst_pkg::POS_WIDTH-1:0] cfg_wdata,
  rmst_in_if.sink                        request,
  rmst_out_if.source                     response
);

  rmst_pkg::rmst_ctl_t ctl;
  rmst_pkg::rmst_sts_t sts;

  rmst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  rmst_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_command    (request.command),
    .in_position   (request.position),
    .in_new_value  (request.new_value),
    .in_range_low  (request.range_low),
    .in_range_high (request.range_high),
    .out_max_value (response.max_value),
    .out_status    (response.status),
    .ctl           (ctl),
    .sts           (sts)
  );

endmodule
